// ===== rtl/bbin_pkg.sv =====
// Shared types and constants for the histogram bin bunching block.
// No dependencies.
`default_nettype none

package bbin_pkg;

  // data_mode register codes
  localparam logic [1:0] MODE_COUNTS = 2'd0;
  localparam logic [1:0] MODE_FREQ   = 2'd1;
  localparam logic [1:0] MODE_POINT  = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  // bunch_status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_ZERO_W = 2'd1;
  localparam logic [1:0] STATUS_SAT    = 2'd2;

  // configuration register indexes
  localparam logic REG_BUNCH_SIZE = 1'b0;
  localparam logic REG_DATA_MODE  = 1'b1;

  // group count field wide enough for the largest bunch
  localparam int CNT_W = 17;

  localparam logic [63:0] SUM_LIM = 64'h7FFF_FFFF_FFFF_FFFF;

  // one closed group handed from the accumulator to the finishing stage
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [63:0] value_sum;
    logic [63:0]        err_sq;
    logic signed [47:0] pos_sum;
    logic [CNT_W-1:0]   count;
    logic signed [31:0] first_edge;
    logic signed [31:0] x_high;
    logic               last;
    logic               acc_ovf;
  } bbin_rec_t;

endpackage

`default_nettype wire

// ===== rtl/bbin_front.sv =====
// Front end: configuration registers, bin intake and group accumulation.
// Depends on bbin_pkg.
`default_nettype none

module bbin_front import bbin_pkg::*; #(
  parameter int MAX_BUNCH = 256,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_index_i,
  input  wire logic [8:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] x_low_i,
  input  wire logic signed [31:0] x_high_i,
  input  wire logic signed [31:0] sample_value_i,
  input  wire logic [30:0]        sample_error_i,
  input  wire logic               spectrum_end_i,
  output logic                    push_o,
  output bbin_rec_t               rec_o,
  input  wire logic               full_i
);

  localparam int CW = $clog2(MAX_BUNCH + 1);
  localparam int BW = (CW > 9) ? CW : 9;
  localparam logic signed [64:0] POS_LIM = {1'b0, SUM_LIM};
  localparam logic signed [64:0] NEG_LIM = -POS_LIM;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_SQ   = 2'd2;
  localparam logic [1:0] F_ACC  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [8:0]         bunch_size_q;
  logic [1:0]         mode_q;
  logic signed [31:0] xl_q, xh_q, y_q;
  logic [30:0]        e_q;
  logic               last_q;
  logic signed [63:0] prodv_q;
  logic [63:0]        prode_q, sq_q;
  logic               big_q;
  logic [CW-1:0]      count_q;
  logic signed [63:0] vsum_q;
  logic [63:0]        esq_q;
  logic signed [47:0] psum_q;
  logic signed [31:0] first_q;
  logic               ovf_q;

  logic [1:0]         mode_eff;
  logic [BW-1:0]      b_eff;
  logic signed [32:0] w;
  logic [32:0]        aw;
  logic signed [64:0] pv;
  logic [63:0]        pe, ew, sq_d;
  logic signed [64:0] s65;
  logic signed [63:0] vsum_new;
  logic [64:0]        esum;
  logic [63:0]        esq_new;
  logic signed [47:0] psum_new;
  logic [CW-1:0]      count_new;
  logic signed [31:0] fe_use;
  logic               ovf_new, close;

  assign mode_eff = (mode_q == MODE_RSVD) ? MODE_COUNTS : mode_q;

  always_comb begin
    if (bunch_size_q == 9'd0) begin
      b_eff = BW'(1);
    end else if (BW'(bunch_size_q) > BW'(MAX_BUNCH)) begin
      b_eff = BW'(MAX_BUNCH);
    end else begin
      b_eff = BW'(bunch_size_q);
    end
  end

  // multiply stage
  assign w  = {xh_q[31], xh_q} - {xl_q[31], xl_q};
  assign aw = w[32] ? 33'(-w) : 33'(w);
  assign pv = y_q * w;
  assign pe = 64'(e_q) * ((mode_eff == MODE_FREQ) ? 64'(aw) : 64'(e_q));

  // squaring stage: frequency mode squares the width-weighted error
  assign ew   = prode_q >> FRAC_BITS;
  assign sq_d = (mode_eff == MODE_FREQ) ? 64'(ew[31:0]) * 64'(ew[31:0]) : prode_q;

  // accumulate stage
  always_comb begin
    ovf_new = ovf_q;
    s65 = {vsum_q[63], vsum_q} + {prodv_q[63], prodv_q};
    if (s65 > POS_LIM) begin
      vsum_new = POS_LIM[63:0];
      ovf_new  = 1'b1;
    end else if (s65 < NEG_LIM) begin
      vsum_new = NEG_LIM[63:0];
      ovf_new  = 1'b1;
    end else begin
      vsum_new = s65[63:0];
    end
    esum = {1'b0, esq_q} + {1'b0, sq_q};
    if ((mode_eff == MODE_FREQ) && big_q) begin
      esq_new = '1;
      ovf_new = 1'b1;
    end else if (esum[64]) begin
      esq_new = '1;
      ovf_new = 1'b1;
    end else begin
      esq_new = esum[63:0];
    end
    psum_new  = (mode_eff == MODE_POINT) ? psum_q + 48'(xl_q) : psum_q;
    count_new = count_q + CW'(1);
    fe_use    = (count_q == '0) ? xl_q : first_q;
    close     = last_q || (BW'(count_new) >= b_eff);
  end

  always_comb begin
    rec_o.mode       = mode_eff;
    rec_o.value_sum  = vsum_new;
    rec_o.err_sq     = esq_new;
    rec_o.pos_sum    = psum_new;
    rec_o.count      = CNT_W'(count_new);
    rec_o.first_edge = fe_use;
    rec_o.x_high     = xh_q;
    rec_o.last       = last_q;
    rec_o.acc_ovf    = ovf_new;
  end

  assign push_o     = (state_q == F_ACC) && close && !full_i;
  assign in_stall_o = (state_q != F_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (in_valid_i) state_d = F_MUL;
      F_MUL:  state_d = F_SQ;
      F_SQ:   state_d = F_ACC;
      F_ACC:  if (!close || !full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      bunch_size_q <= 9'd1;
      mode_q       <= MODE_COUNTS;
      count_q      <= '0;
      vsum_q       <= '0;
      esq_q        <= '0;
      psum_q       <= '0;
      first_q      <= '0;
      ovf_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_BUNCH_SIZE) begin
          bunch_size_q <= cfg_data_i;
        end else begin
          mode_q <= cfg_data_i[1:0];
        end
        count_q <= '0;
        vsum_q  <= '0;
        esq_q   <= '0;
        psum_q  <= '0;
        first_q <= '0;
        ovf_q   <= 1'b0;
      end else if (state_q == F_ACC) begin
        if (!close) begin
          count_q <= count_new;
          vsum_q  <= vsum_new;
          esq_q   <= esq_new;
          psum_q  <= psum_new;
          first_q <= fe_use;
          ovf_q   <= ovf_new;
        end else if (!full_i) begin
          count_q <= '0;
          vsum_q  <= '0;
          esq_q   <= '0;
          psum_q  <= '0;
          first_q <= '0;
          ovf_q   <= 1'b0;
        end
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if ((state_q == F_IDLE) && in_valid_i) begin
      xl_q   <= x_low_i;
      xh_q   <= x_high_i;
      y_q    <= sample_value_i;
      e_q    <= sample_error_i;
      last_q <= spectrum_end_i;
    end
    if (state_q == F_MUL) begin
      prodv_q <= (mode_eff == MODE_FREQ) ? pv[63:0] : 64'(y_q);
      prode_q <= pe;
    end
    if (state_q == F_SQ) begin
      sq_q  <= sq_d;
      big_q <= |ew[63:32];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bbin_fifo.sv =====
// Two-word queue of closed groups between accumulator and finisher.
// Depends on bbin_pkg.
`default_nettype none

module bbin_fifo import bbin_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire bbin_rec_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           avail_o,
  output bbin_rec_t      data_o
);

  bbin_rec_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/bbin_div.sv =====
// Restoring divider, one quotient bit per cycle, 64 by 33 bit unsigned.
// No dependencies.
`default_nettype none

module bbin_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [32:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quot_o
);

  logic        run_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] q_q;
  logic [32:0] rem_q, dvs_q;
  logic [33:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, q_q[63]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? 33'(rem_sh - {1'b0, dvs_q}) : rem_sh[32:0];
      q_q   <= {q_q[62:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bbin_back.sv =====
// Back end: root of the error sum, divisions, clamping, result register.
// Depends on bbin_pkg and bbin_div.
`default_nettype none

module bbin_back import bbin_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           avail_i,
  input  wire bbin_rec_t      rec_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic signed [31:0]  bunch_x_low_o,
  output logic signed [31:0]  bunch_x_high_o,
  output logic signed [31:0]  bunch_value_o,
  output logic [30:0]         bunch_error_o,
  output logic [1:0]          bunch_status_o,
  output logic                spectrum_last_o
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_SQRT  = 3'd1;
  localparam logic [2:0] B_SETUP = 3'd2;
  localparam logic [2:0] B_START = 3'd3;
  localparam logic [2:0] B_DIV   = 3'd4;
  localparam logic [2:0] B_FIN   = 3'd5;
  localparam logic [2:0] B_OUT   = 3'd6;

  localparam logic [1:0] JOB_VAL = 2'd0;
  localparam logic [1:0] JOB_ERR = 2'd1;
  localparam logic [1:0] JOB_POS = 2'd2;

  localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN32 = -64'sh0000_0000_8000_0000;

  logic [2:0]         state_q;
  bbin_rec_t          rec_q;
  logic [63:0]        rad_q;
  logic [33:0]        rem_q;
  logic [31:0]        root_q;
  logic [4:0]         it_q;
  logic [1:0]         job_q;
  logic               zw_q;
  logic signed [63:0] qval_q, qpos_q;
  logic [63:0]        qerr_q;

  logic signed [31:0] oxl_q, oxh_q, oval_q;
  logic [30:0]        oerr_q;
  logic [1:0]         ost_q;
  logic               olast_q, ovalid_q;

  // square root digit step
  logic [35:0] rem_sh, trial;
  logic        sq_ge;
  assign rem_sh = {rem_q, rad_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_ge  = rem_sh >= trial;

  // division operands
  logic signed [32:0] gw;
  logic [32:0]        agw, divisor;
  logic [63:0]        vs_abs, pos_abs, dividend, quot;
  logic               neg, div_start, div_done, freq;
  logic signed [63:0] qs;

  assign freq    = (rec_q.mode == MODE_FREQ);
  assign gw      = {rec_q.x_high[31], rec_q.x_high} - {rec_q.first_edge[31], rec_q.first_edge};
  assign agw     = gw[32] ? 33'(-gw) : 33'(gw);
  assign vs_abs  = rec_q.value_sum[63] ? 64'(-rec_q.value_sum) : 64'(rec_q.value_sum);
  assign pos_abs = rec_q.pos_sum[47] ? 64'(-rec_q.pos_sum) : 64'(rec_q.pos_sum);
  assign divisor = freq ? agw : 33'(rec_q.count);

  always_comb begin
    unique case (job_q)
      JOB_VAL: begin
        dividend = vs_abs;
        neg      = rec_q.value_sum[63] ^ (freq & gw[32]);
      end
      JOB_ERR: begin
        dividend = freq ? (64'(root_q) << FRAC_BITS) : 64'(root_q);
        neg      = 1'b0;
      end
      JOB_POS: begin
        dividend = pos_abs;
        neg      = rec_q.pos_sum[47];
      end
      default: begin
        dividend = '0;
        neg      = 1'b0;
      end
    endcase
  end

  assign div_start = (state_q == B_START);
  assign qs        = neg ? -$signed(quot) : $signed(quot);

  bbin_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // final assembly and clamping
  logic signed [63:0] val_s, xl_s;
  logic [63:0]        err_u;
  logic               sat;
  logic signed [31:0] val_c, xl_c;
  logic [30:0]        err_c;
  logic [1:0]         st;

  always_comb begin
    sat   = 1'b0;
    val_s = rec_q.value_sum;
    err_u = 64'(root_q);
    xl_s  = 64'(rec_q.first_edge);
    if (rec_q.mode == MODE_FREQ || rec_q.mode == MODE_POINT) begin
      val_s = qval_q;
      err_u = qerr_q;
    end
    if (rec_q.mode == MODE_POINT) xl_s = qpos_q;
    if (val_s > MAX32) begin
      val_c = 32'sh7FFF_FFFF;
      sat   = 1'b1;
    end else if (val_s < MIN32) begin
      val_c = 32'sh8000_0000;
      sat   = 1'b1;
    end else begin
      val_c = val_s[31:0];
    end
    if (xl_s > MAX32) begin
      xl_c = 32'sh7FFF_FFFF;
      sat  = 1'b1;
    end else if (xl_s < MIN32) begin
      xl_c = 32'sh8000_0000;
      sat  = 1'b1;
    end else begin
      xl_c = xl_s[31:0];
    end
    if (err_u > 64'h7FFF_FFFF) begin
      err_c = '1;
      sat   = 1'b1;
    end else begin
      err_c = err_u[30:0];
    end
    if (zw_q) begin
      val_c = '0;
      err_c = '0;
      st    = STATUS_ZERO_W;
    end else if (sat || rec_q.acc_ovf) begin
      st = STATUS_SAT;
    end else begin
      st = STATUS_OK;
    end
  end

  assign pop_o = (state_q == B_IDLE) && avail_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ovalid_q <= 1'b0;
      it_q     <= '0;
      job_q    <= JOB_VAL;
      zw_q     <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: if (avail_i) begin
          it_q    <= '0;
          zw_q    <= 1'b0;
          state_q <= B_SQRT;
        end
        B_SQRT: begin
          it_q <= it_q + 5'd1;
          if (it_q == 5'd31) state_q <= B_SETUP;
        end
        B_SETUP: begin
          job_q <= JOB_VAL;
          if (rec_q.mode == MODE_POINT) begin
            state_q <= B_START;
          end else if (freq && gw != '0) begin
            state_q <= B_START;
          end else begin
            zw_q    <= freq;
            state_q <= B_FIN;
          end
        end
        B_START: state_q <= B_DIV;
        B_DIV: if (div_done) begin
          if (job_q == JOB_VAL) begin
            job_q   <= JOB_ERR;
            state_q <= B_START;
          end else if (job_q == JOB_ERR && !freq) begin
            job_q   <= JOB_POS;
            state_q <= B_START;
          end else begin
            state_q <= B_FIN;
          end
        end
        B_FIN: begin
          ovalid_q <= 1'b1;
          state_q  <= B_OUT;
        end
        B_OUT: if (!out_stall_i) begin
          ovalid_q <= 1'b0;
          state_q  <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q  <= rec_i;
      rad_q  <= rec_i.err_sq;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == B_SQRT) begin
      rem_q  <= sq_ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      root_q <= {root_q[30:0], sq_ge};
      rad_q  <= rad_q << 2;
    end
    if (state_q == B_DIV && div_done) begin
      unique case (job_q)
        JOB_VAL: qval_q <= qs;
        JOB_ERR: qerr_q <= quot;
        JOB_POS: qpos_q <= qs;
        default: qpos_q <= qs;
      endcase
    end
    if (state_q == B_FIN) begin
      oxl_q   <= xl_c;
      oxh_q   <= (rec_q.mode == MODE_POINT) ? 32'sd0 : rec_q.x_high;
      oval_q  <= val_c;
      oerr_q  <= err_c;
      ost_q   <= st;
      olast_q <= rec_q.last;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign bunch_x_low_o   = oxl_q;
  assign bunch_x_high_o  = oxh_q;
  assign bunch_value_o   = oval_q;
  assign bunch_error_o   = oerr_q;
  assign bunch_status_o  = ost_q;
  assign spectrum_last_o = olast_q;

endmodule

`default_nettype wire

// ===== rtl/histogram_bin_bunching_top.sv =====
// Histogram bin bunching: groups spectrum bins, sums or normalises values
// and combines errors in quadrature. Front: multiply, square and accumulate
// one bin at a time; a closing bin waits on a full queue. Back, per group: a
// root, then divisions (none in counts mode or zero width, two in frequency,
// three in point mode), bookkeeping; a two-word queue of closed groups between.
// Async active-low reset: bunch_size 1, counts mode, open group cleared.
`default_nettype none

module histogram_bin_bunching_top import bbin_pkg::*; #(
  parameter int MAX_BUNCH = 256,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [8:0]         cfg_data_i,
  // bin words in
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] x_low_i,
  input  wire logic signed [31:0] x_high_i,
  input  wire logic signed [31:0] sample_value_i,
  input  wire logic [30:0]        sample_error_i,
  input  wire logic               spectrum_end_i,
  // group words out
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      bunch_x_low_o,
  output logic signed [31:0]      bunch_x_high_o,
  output logic signed [31:0]      bunch_value_o,
  output logic [30:0]             bunch_error_o,
  output logic [1:0]              bunch_status_o,
  output logic                    spectrum_last_o
);

  // writes are held off while a bin is still in the front pipeline;
  // closed groups already queued are unaffected by a write
  assign cfg_ready_o = !in_stall_o;

  logic      push, full, pop, avail;
  bbin_rec_t rec_in, rec_out;

  // intake and accumulation; pushes one word per closed group
  bbin_front #(
    .MAX_BUNCH (MAX_BUNCH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .x_low_i        (x_low_i),
    .x_high_i       (x_high_i),
    .sample_value_i (sample_value_i),
    .sample_error_i (sample_error_i),
    .spectrum_end_i (spectrum_end_i),
    .push_o         (push),
    .rec_o          (rec_in),
    .full_i         (full)
  );

  // decouples the accumulator from the slow root/divide path
  bbin_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (rec_out)
  );

  // root, divisions, clamping and the output register
  bbin_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (avail),
    .rec_i           (rec_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bunch_x_low_o   (bunch_x_low_o),
    .bunch_x_high_o  (bunch_x_high_o),
    .bunch_value_o   (bunch_value_o),
    .bunch_error_o   (bunch_error_o),
    .bunch_status_o  (bunch_status_o),
    .spectrum_last_o (spectrum_last_o)
  );

  // a closed group must never be pushed into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full)) else $error("group pushed into full queue");

  // nothing popped from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> avail) else $error("pop from empty queue");

  // zero width result carries zero value and error
  a_zero_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bunch_status_o == STATUS_ZERO_W) |->
      (bunch_value_o == '0 && bunch_error_o == '0))
    else $error("zero width result not cleared");

endmodule

`default_nettype wire

// ===== bench/histogram_bin_bunching_top_tb.sv =====
// Testbench for histogram_bin_bunching_top: directed, back-pressure and random bin streams,
// checked word by word against a behavioural predictor of the bunching arithmetic.
// Depends on bbin_pkg and the block's RTL only.
`timescale 1ns / 100ps

module histogram_bin_bunching_top_tb;
  import bbin_pkg::*;

  localparam int  BUNCH_CAP   = 256;
  localparam int  FRAC        = 16;
  localparam int  TOTAL_BINS  = 1150;
  // worst group: root, three divisions, bookkeeping, plus a two-deep queue
  localparam int  SETTLE_CYC  = 400;
  localparam longint SAT_LIM  = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [31:0] x_low;
    logic signed [31:0] x_high;
    logic signed [31:0] value;
    logic [30:0]        error;
    logic               last;
  } bin_word_t;

  typedef struct {
    logic signed [31:0] x_low;
    logic signed [31:0] x_high;
    logic signed [31:0] value;
    logic [30:0]        error;
    logic [1:0]         status;
    logic               last;
  } group_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = REG_BUNCH_SIZE;
  logic [8:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] x_low_i = '0;
  logic signed [31:0] x_high_i = '0;
  logic signed [31:0] sample_value_i = '0;
  logic [30:0]        sample_error_i = '0;
  logic               spectrum_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] bunch_x_low_o;
  logic signed [31:0] bunch_x_high_o;
  logic signed [31:0] bunch_value_o;
  logic [30:0]        bunch_error_o;
  logic [1:0]         bunch_status_o;
  logic               spectrum_last_o;

  histogram_bin_bunching_top i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: register copies and the open group.
  logic [8:0]  bunch_reg;
  logic [1:0]  mode_reg;
  int unsigned grp_count;
  longint      val_sum;
  longint unsigned err_sq_sum;
  longint      pos_sum;
  longint      first_edge;
  bit          sum_ovf;

  group_word_t expected_groups[$];
  int          fail_count = 0;
  int          bins_sent = 0;
  int          send_idle_pct = 0;   // sender gap chance, percent
  int          recv_idle_pct = 0;   // receiver stall chance, percent
  int          hold_request = 0;    // long receiver hold-off, in cycles
  int          hold_left = 0;
  longint      edge_cursor = 0;     // running bin edge for well-formed spectra

  function automatic void open_group_clear();
    grp_count = 0; val_sum = 0; err_sq_sum = 0; pos_sum = 0; first_edge = 0;
    sum_ovf = 1'b0;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    if (b > 0 && a > SAT_LIM - b) begin
      sum_ovf = 1'b1;
      return SAT_LIM;
    end
    if (b < 0 && a < -SAT_LIM - b) begin
      sum_ovf = 1'b1;
      return -SAT_LIM;
    end
    return a + b;
  endfunction

  function automatic longint clamp_s32(longint v, inout bit sat);
    if (v > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      sat = 1'b1;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  function automatic longint unsigned clamp_err(longint unsigned v, inout bit sat);
    if (v > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 64'h7FFF_FFFF;
    end
    return v;
  endfunction

  // Accumulate one bin; returns 1 with the group word when the bin closes a group.
  function automatic bit bunch_bin(input bin_word_t b, output group_word_t g);
    longint          xl, xh, y, w, gw, num;
    longint unsigned e, aw, ew, agw, rest, root, bitv, sq;
    int unsigned     limit;
    logic [1:0]      mode;
    bit              sat;
    logic [1:0]      st;
    xl = longint'(b.x_low);
    xh = longint'(b.x_high);
    y = longint'(b.value);
    e = longint'(b.error);
    sat = 1'b0;
    limit = (bunch_reg == 0) ? 1 : (bunch_reg > BUNCH_CAP ? BUNCH_CAP : bunch_reg);
    mode = (mode_reg == MODE_RSVD) ? MODE_COUNTS : mode_reg;
    if (grp_count == 0) first_edge = xl;
    if (mode == MODE_FREQ) begin
      w = xh - xl;
      aw = (w < 0) ? -w : w;
      ew = (e * aw) >> FRAC;
      val_sum = sat_add(val_sum, y * w);
      if (ew > 64'hFFFF_FFFF) begin
        sum_ovf = 1'b1;
        err_sq_sum = '1;
      end else begin
        sq = err_sq_sum + ew * ew;
        if (sq < err_sq_sum) begin
          sum_ovf = 1'b1;
          sq = '1;
        end
        err_sq_sum = sq;
      end
    end else begin
      val_sum = sat_add(val_sum, y);
      sq = err_sq_sum + e * e;
      if (sq < err_sq_sum) begin
        sum_ovf = 1'b1;
        sq = '1;
      end
      err_sq_sum = sq;
      if (mode == MODE_POINT) pos_sum = sat_add(pos_sum, xl);
    end
    grp_count++;
    if (grp_count < limit && !b.last) return 1'b0;

    // integer square root, digit by digit
    rest = err_sq_sum; root = 0; bitv = 64'h1 << 62;
    while (bitv > rest) bitv >>= 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end

    st = STATUS_OK;
    if (mode == MODE_FREQ) begin
      gw = xh - first_edge;
      g.x_low = first_edge;
      g.x_high = xh;
      if (gw == 0) begin
        g.value = '0;
        g.error = '0;
        st = STATUS_ZERO_W;
      end else begin
        agw = (gw < 0) ? -gw : gw;
        g.value = clamp_s32(val_sum / gw, sat);
        g.error = clamp_err((root << FRAC) / agw, sat);
      end
    end else if (mode == MODE_POINT) begin
      num = grp_count;
      g.x_low = clamp_s32(pos_sum / num, sat);
      g.x_high = '0;
      g.value = clamp_s32(val_sum / num, sat);
      g.error = clamp_err(root / longint'(grp_count), sat);
    end else begin
      g.x_low = first_edge;
      g.x_high = xh;
      g.value = clamp_s32(val_sum, sat);
      g.error = clamp_err(root, sat);
    end
    if (st == STATUS_OK && (sat || sum_ovf)) st = STATUS_SAT;
    g.status = st;
    g.last = b.last;
    open_group_clear();
    return 1'b1;
  endfunction

  // Receiver: random stalls, or a long counted hold-off on request.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker: every accepted group word against the oldest expectation.
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    group_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_groups.size() == 0) begin
        $display("%0t: unexpected group word, x_low %0d value %0d", $time,
                 bunch_x_low_o, bunch_value_o);
        fail_count++;
      end else begin
        want = expected_groups.pop_front();
        check_field("bunch_x_low", want.x_low, bunch_x_low_o);
        check_field("bunch_x_high", want.x_high, bunch_x_high_o);
        check_field("bunch_value", want.value, bunch_value_o);
        check_field("bunch_error", want.error, bunch_error_o);
        check_field("bunch_status", want.status, bunch_status_o);
        check_field("spectrum_last", want.last, spectrum_last_o);
      end
    end
  end

  // Offer one bin word, possibly after a random gap; predicts on acceptance.
  task automatic send_bin(bin_word_t b);
    group_word_t g;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_low_i <= b.x_low;
    x_high_i <= b.x_high;
    sample_value_i <= b.value;
    sample_error_i <= b.error;
    spectrum_end_i <= b.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bins_sent++;
    if (bunch_bin(b, g)) expected_groups.push_back(g);
  endtask

  // Stop sending, let every expected word out, then let the back end settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_groups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [8:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_BUNCH_SIZE) bunch_reg = data;
    else mode_reg = data[1:0];
    open_group_clear();
  endtask

  task automatic configure(logic [8:0] bunch, logic [1:0] mode);
    drain();
    write_reg(REG_BUNCH_SIZE, bunch);
    write_reg(REG_DATA_MODE, {7'd0, mode});
  endtask

  function automatic bin_word_t mk_bin(longint xl, longint xh, longint y, longint e, bit last);
    bin_word_t b;
    b.x_low = xl; b.x_high = xh; b.value = y; b.error = e; b.last = last;
    return b;
  endfunction

  // Random bin: mostly contiguous edges and moderate values, some full-range noise.
  function automatic bin_word_t rand_bin(bit last);
    bin_word_t b;
    longint    w;
    if ($urandom_range(9) == 0) begin
      b.x_low = $urandom; b.x_high = $urandom; b.value = $urandom;
      b.error = $urandom;
    end else begin
      w = ($urandom_range(19) == 0) ? 0 : $urandom_range(32'h4_0000, 1);
      if ($urandom_range(15) == 0) w = -w;
      if ($urandom_range(49) == 0) edge_cursor = $signed($urandom_range(32'hFFFF, 0)) - 32768;
      b.x_low = edge_cursor;
      b.x_high = edge_cursor + w;
      edge_cursor = edge_cursor + w;
      if (edge_cursor > 64'sh3FFF_FFFF || edge_cursor < -64'sh3FFF_FFFF) edge_cursor = 0;
      b.value = $signed($urandom_range(32'h00FF_FFFF, 0)) - 32'sh0080_0000;
      b.error = $urandom_range(32'h0003_FFFF, 0);
    end
    b.last = last;
    return b;
  endfunction

  // Extremes of every field, every mode, zero width and the saturation cases.
  task automatic test_directed();
    configure(9'd1, MODE_COUNTS);
    send_bin(mk_bin(-64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'h7FFF_FFFF, 1'b0));
    send_bin(mk_bin(64'sh7FFF_FFFF, -64'sh8000_0000, -64'sh8000_0000, 0, 1'b1));
    configure(9'd3, MODE_COUNTS);        // sum above the 32 bit range clamps
    repeat (3) send_bin(mk_bin(0, 1, 64'sh7FFF_FFFF, 64'h7FFF_FFFF, 1'b0));
    send_bin(mk_bin(5, 9, -7, 3, 1'b1)); // short group closed by spectrum end
    configure(9'd2, MODE_FREQ);
    send_bin(mk_bin(64'h1_0000, 64'h1_0000, 100, 5, 1'b0));   // zero group width
    send_bin(mk_bin(64'h1_0000, 64'h1_0000, 200, 5, 1'b0));
    send_bin(mk_bin(64'h2_0000, 64'h3_0000, 64'h5_0000, 64'h1_0000, 1'b0));
    send_bin(mk_bin(64'h3_0000, 64'h5_0000, 64'h2_0000, 64'h2_0000, 1'b1));
    // widest negative width, huge product: the 64 bit sums saturate
    send_bin(mk_bin(64'sh7FFF_FFFF, -64'sh8000_0000, -64'sh8000_0000, 64'h7FFF_FFFF, 1'b0));
    send_bin(mk_bin(64'sh7FFF_FFFF, -64'sh8000_0000, -64'sh8000_0000, 64'h7FFF_FFFF, 1'b0));
    configure(9'd4, MODE_POINT);
    send_bin(mk_bin(64'sh7FFF_FFFF, 0, 64'sh7FFF_FFFF, 64'h7FFF_FFFF, 1'b0));
    send_bin(mk_bin(64'sh7FFF_FFFF, 0, 64'sh7FFF_FFFF, 64'h7FFF_FFFF, 1'b0));
    send_bin(mk_bin(-64'sh8000_0000, 0, -3, 1, 1'b1));
    configure(9'd0, MODE_RSVD);          // size zero acts as one, mode three as counts
    send_bin(mk_bin(10, 20, 30, 40, 1'b0));
    send_bin(mk_bin(-10, -20, -30, 40, 1'b1));
    configure(9'd511, MODE_COUNTS);      // clipped to the largest bunch
    send_bin(mk_bin(1, 2, 3, 4, 1'b0));
    send_bin(mk_bin(2, 3, 4, 5, 1'b1));
  endtask

  // Receiver holds off for a long stretch while bins keep coming.
  task automatic test_backpressure();
    configure(9'd1, MODE_POINT);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 3000;
    repeat (30) send_bin(rand_bin($urandom_range(1)));
  endtask

  // Random spectra under a spread of settings; a few are noise or cut short.
  task automatic test_random(int send_pct, int recv_pct, int quota);
    int          stop_at, len, big;
    logic [8:0]  bsz;
    logic [1:0]  md;
    stop_at = bins_sent + quota;
    while (bins_sent < stop_at) begin
      big = ($urandom_range(11) == 0);
      bsz = big ? ($urandom_range(1) ? 9'd256 : 9'd511) : $urandom_range(8, 0);
      md = $urandom_range(3);
      configure(bsz, md);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (big ? 1 : 6) begin
        len = big ? $urandom_range(300, 200) : $urandom_range(3 * (bsz + 1), 1);
        if ($urandom_range(7) == 0) begin
          repeat (len) send_bin(rand_bin($urandom_range(3) == 0));
        end else begin
          for (int k = 0; k < len; k++) send_bin(rand_bin(k == len - 1));
        end
      end
    end
  endtask

  initial begin
    bunch_reg = 9'd1;
    mode_reg = MODE_COUNTS;
    open_group_clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(29, 70, 360);
    test_random(70, 29, 360);
    test_random(0, 0, TOTAL_BINS - bins_sent);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bbin_pkg.sv
rtl/bbin_front.sv
rtl/bbin_fifo.sv
rtl/bbin_div.sv
rtl/bbin_back.sv
rtl/histogram_bin_bunching_top.sv
bench/histogram_bin_bunching_top_tb.sv
